// ----- rtl/core/blti_pkg.sv -----
package blti_pkg;

   // default sizes
   localparam int TABLE_DEPTH_DEF = 256;
   localparam int NUM_TABLES      = 8;
   localparam int FRAC_BITS_DEF   = 12;

   // request codes
   localparam logic [1:0] REQ_ENTRY  = 2'd0;
   localparam logic [1:0] REQ_HEADER = 2'd1;
   localparam logic [1:0] REQ_QUERY  = 2'd2;

   // result status codes
   localparam logic [2:0] ST_INTERP = 3'd0;
   localparam logic [2:0] ST_BELOW  = 3'd1;
   localparam logic [2:0] ST_ABOVE  = 3'd2;
   localparam logic [2:0] ST_WRITE  = 3'd3;
   localparam logic [2:0] ST_ERROR  = 3'd4;

   // log rate reported below the table start
   localparam logic signed [19:0] LOG_RATE_FLOOR = 20'sh80000;

   localparam logic [15:0] INV_STEP_RESET = 16'd5120;

   // log2(10) in Q2.28
   localparam logic [29:0] LOG2_TEN_Q28 = 30'd891723283;

   // pipeline depths of the three sections
   localparam int LOC_STAGES = 3;
   localparam int INT_STAGES = 3;
   localparam int EXP_STAGES = 18;

   // abundance bin thresholds in quarters
   localparam int BIN_QUARTERS [7] = '{-14, -10, -7, -5, -3, -1, 1};

   // 2^(2^-(k+1)) in Q1.30
   localparam logic [30:0] POW2_TAB [16] = '{
      31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
      31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
      31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544,
      31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
   };

   // per item tag that travels with every transfer
   typedef struct packed {
      logic              valid;
      logic [2:0]        status;
      logic              lin;
      logic signed [19:0] lr;
   } tag_type;

   // locate section to interpolation section
   typedef struct packed {
      tag_type           tag;
      logic              qlive;
      logic [35:0]       pos;
      logic [8:0]        cnt;
      logic [2:0]        tb;
      logic              we;
      logic [2:0]        wtsel;
      logic [8:0]        widx;
      logic signed [19:0] wdata;
   } loc_type;

endpackage

// ----- rtl/core/blti_locate.sv -----
module blti_locate
   import blti_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [1:0]        req_type,
   input  logic [2:0]        table_sel,
   input  logic [8:0]        entry_index,
   input  logic signed [19:0] table_value,
   input  logic signed [19:0] log_temp,
   input  logic signed [19:0] log_abund,
   input  logic [15:0]       inv_step,
   output loc_type           loc
);

   logic              v1_ff;
   logic [1:0]        req1_ff;
   logic [2:0]        tsel1_ff;
   logic [8:0]        idx1_ff;
   logic signed [19:0] tval1_ff;
   logic signed [19:0] temp1_ff;
   logic [2:0]        tb1_ff;
   logic [6:0]        gt;
   logic [2:0]        tb_in;

   logic signed [19:0] start_ff [NUM_TABLES];
   logic [8:0]        count_ff [NUM_TABLES];

   logic signed [19:0] hstart;
   logic [8:0]        hcnt;
   logic [20:0]       diff;
   logic              hdr_ok;
   logic              ent_ok;
   tag_type           tag2_in, tag2_ff;
   logic              qlive2_in, qlive2_ff;
   logic              we2_in, we2_ff;
   logic [19:0]       diff2_ff;
   logic [8:0]        cnt2_ff;
   logic [2:0]        tb2_ff;
   logic [2:0]        wtsel2_ff;
   logic [8:0]        widx2_ff;
   logic signed [19:0] wdata2_ff;
   loc_type           loc_in, loc_ff;

   // abundance bin select
   always_comb begin
      for (int i = 0; i < 7; i++) begin
         gt[i] = int'(log_abund) > BIN_QUARTERS[i] * (2 ** (FRAC_BITS - 2));
      end
      tb_in = 3'($countones(gt));
   end

   // input capture
   always_ff @(posedge clock) begin
      v1_ff    <= in_valid;
      req1_ff  <= req_type;
      tsel1_ff <= table_sel;
      idx1_ff  <= entry_index;
      tval1_ff <= table_value;
      temp1_ff <= log_temp;
      tb1_ff   <= tb_in;
      if (reset) begin
         v1_ff <= 1'b0;
      end
   end

   // header lookup and request decode
   assign hstart = start_ff[tb1_ff];
   assign hcnt   = count_ff[tb1_ff];
   assign diff   = {temp1_ff[19], temp1_ff} - {hstart[19], hstart};
   assign hdr_ok = int'(idx1_ff) <= TABLE_DEPTH;
   assign ent_ok = int'(idx1_ff) < TABLE_DEPTH;

   always_comb begin
      tag2_in.valid  = v1_ff;
      tag2_in.status = ST_ERROR;
      tag2_in.lin    = 1'b0;
      tag2_in.lr     = '0;
      qlive2_in      = 1'b0;
      we2_in         = 1'b0;
      unique case (req1_ff)
         REQ_ENTRY: begin
            if (ent_ok) begin
               tag2_in.status = ST_WRITE;
               we2_in         = v1_ff;
            end
         end
         REQ_HEADER: begin
            if (hdr_ok) begin
               tag2_in.status = ST_WRITE;
            end
         end
         REQ_QUERY: begin
            if (hcnt != 9'd0) begin
               if (diff[20]) begin
                  tag2_in.status = ST_BELOW;
                  tag2_in.lr     = LOG_RATE_FLOOR;
               end else begin
                  tag2_in.status = ST_INTERP;
                  tag2_in.lin    = 1'b1;
                  qlive2_in      = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // table headers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TABLES; i++) begin
            start_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else if (v1_ff && req1_ff == REQ_HEADER && hdr_ok) begin
         start_ff[tsel1_ff] <= tval1_ff;
         count_ff[tsel1_ff] <= idx1_ff;
      end
   end

   // position stage registers
   always_ff @(posedge clock) begin
      tag2_ff   <= tag2_in;
      qlive2_ff <= qlive2_in;
      we2_ff    <= we2_in;
      diff2_ff  <= diff[19:0];
      cnt2_ff   <= hcnt;
      tb2_ff    <= tb1_ff;
      wtsel2_ff <= tsel1_ff;
      widx2_ff  <= idx1_ff;
      wdata2_ff <= tval1_ff;
      if (reset) begin
         tag2_ff.valid <= 1'b0;
         we2_ff        <= 1'b0;
      end
   end

   // table position from temperature offset
   always_comb begin
      loc_in.tag   = tag2_ff;
      loc_in.qlive = qlive2_ff;
      loc_in.pos   = diff2_ff * inv_step;
      loc_in.cnt   = cnt2_ff;
      loc_in.tb    = tb2_ff;
      loc_in.we    = we2_ff;
      loc_in.wtsel = wtsel2_ff;
      loc_in.widx  = widx2_ff;
      loc_in.wdata = wdata2_ff;
   end

   always_ff @(posedge clock) begin
      loc_ff <= loc_in;
      if (reset) begin
         loc_ff.tag.valid <= 1'b0;
         loc_ff.we        <= 1'b0;
      end
   end

   assign loc = loc_ff;

endmodule

// ----- rtl/core/blti_interp.sv -----
module blti_interp
   import blti_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  loc_type loc,
   output tag_type res
);

   localparam int FB        = FRAC_BITS + 8;
   localparam int J_W       = 36 - FB;
   localparam int DEPTH_W   = $clog2(TABLE_DEPTH);
   localparam int ADDR_W    = 3 + DEPTH_W;
   localparam int MEM_DEPTH = NUM_TABLES * (2 ** DEPTH_W);
   localparam int PW        = FB + 22;
   localparam logic signed [PW-1:0] HALF = PW'(1) << (FB - 1);

   logic [J_W-1:0]    j;
   logic [FB-1:0]     fr;
   logic [8:0]        cm1;
   logic              above;
   logic              at_last;
   int                sel0;
   logic [ADDR_W-1:0] rd0_addr, rd1_addr, wr_addr;
   tag_type           tag4_in, tag4_ff;
   logic              interp4_in, interp4_ff;
   logic [FB-1:0]     fr4_ff;

   logic signed [19:0] mem [MEM_DEPTH];
   logic signed [19:0] e0_ff, e1_ff;

   logic signed [20:0]   delta;
   logic signed [PW-1:0] prod_in, prod5_ff;
   tag_type              tag5_ff;
   logic                 interp5_ff;
   logic signed [19:0]   e05_ff;
   logic signed [PW-1:0] acc;
   logic signed [PW-1:0] sh;
   logic [20:0]          lr_sum;
   tag_type              res_in, res_ff;

   // split position and classify against the table end
   assign j       = loc.pos[35:FB];
   assign fr      = loc.pos[FB-1:0];
   assign cm1     = loc.cnt - 9'd1;
   assign above   = int'(j) > int'(cm1) || (int'(j) == int'(cm1) && fr != '0);
   assign at_last = int'(j) == int'(cm1) && fr == '0;
   assign sel0    = (above || at_last) ? int'(cm1) : int'(j);

   assign rd0_addr = {loc.tb, DEPTH_W'(sel0)};
   assign rd1_addr = {loc.tb, DEPTH_W'(int'(j) + 1)};
   assign wr_addr  = {loc.wtsel, DEPTH_W'(loc.widx)};

   always_comb begin
      tag4_in    = loc.tag;
      interp4_in = loc.qlive && !above && !at_last;
      if (loc.qlive) begin
         tag4_in.status = above ? ST_ABOVE : ST_INTERP;
      end
   end

   // entry memory, writes and reads at the same stage keep item order
   always_ff @(posedge clock) begin
      if (loc.we) begin
         mem[wr_addr] <= loc.wdata;
      end
      e0_ff <= mem[rd0_addr];
      e1_ff <= mem[rd1_addr];
   end

   always_ff @(posedge clock) begin
      tag4_ff    <= tag4_in;
      interp4_ff <= interp4_in;
      fr4_ff     <= fr;
      if (reset) begin
         tag4_ff.valid <= 1'b0;
      end
   end

   // slope times fraction
   assign delta   = {e1_ff[19], e1_ff} - {e0_ff[19], e0_ff};
   assign prod_in = delta * $signed({1'b0, fr4_ff});

   always_ff @(posedge clock) begin
      tag5_ff    <= tag4_ff;
      interp5_ff <= interp4_ff;
      e05_ff     <= e0_ff;
      prod5_ff   <= prod_in;
      if (reset) begin
         tag5_ff.valid <= 1'b0;
      end
   end

   // round, floor and add base entry
   assign acc    = prod5_ff + HALF;
   assign sh     = acc >>> FB;
   assign lr_sum = {e05_ff[19], e05_ff} + sh[20:0];

   always_comb begin
      res_in = tag5_ff;
      if (tag5_ff.lin) begin
         res_in.lr = interp5_ff ? $signed(lr_sum[19:0]) : e05_ff;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (reset) begin
         res_ff.valid <= 1'b0;
      end
   end

   assign res = res_ff;

endmodule

// ----- rtl/core/blti_exp2.sv -----
module blti_exp2
   import blti_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  tag_type           tag,
   output tag_type           out_tag,
   output logic signed [8:0] exponent,
   output logic [15:0]       mantissa
);

   localparam int S   = FRAC_BITS + 28;
   localparam int E_W = 51 - S;

   logic signed [50:0]    y_in, y_ff;
   tag_type               tagy_ff;

   logic [31:0]           src_m [16];
   logic [15:0]           src_f [16];
   logic signed [E_W-1:0] src_e [16];
   tag_type               src_t [16];
   logic [62:0]           prod_w [16];
   logic [62:0]           rnd_w [16];
   logic [31:0]           m_in [16];

   logic [31:0]           m_ff [16];
   logic [15:0]           f_ff [16];
   logic signed [E_W-1:0] e_ff [16];
   tag_type               t_ff [16];

   logic [32:0]           m_sum;
   logic [17:0]           mr;
   logic                  ovf;
   int                    e_adj;
   logic signed [8:0]     exp_in, exp_ff;
   logic [15:0]           man_in, man_ff;
   tag_type               out_ff;

   // log2 of the rate in fixed point
   assign y_in = tag.lr * $signed({1'b0, LOG2_TEN_Q28});

   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      tagy_ff <= tag;
      if (reset) begin
         tagy_ff.valid <= 1'b0;
      end
   end

   // one factor stage per fraction bit
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         if (k == 0) begin
            src_m[k] = 32'h4000_0000;
            src_f[k] = y_ff[S-1:S-16];
            src_e[k] = y_ff[50:S];
            src_t[k] = tagy_ff;
         end else begin
            src_m[k] = m_ff[k-1];
            src_f[k] = f_ff[k-1];
            src_e[k] = e_ff[k-1];
            src_t[k] = t_ff[k-1];
         end
         prod_w[k] = 63'(src_m[k]) * 63'(POW2_TAB[k]);
         rnd_w[k]  = prod_w[k] + 63'(2 ** 29);
         m_in[k]   = src_f[k][15-k] ? rnd_w[k][61:30] : src_m[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 16; k++) begin
         m_ff[k] <= m_in[k];
         f_ff[k] <= src_f[k];
         e_ff[k] <= src_e[k];
         t_ff[k] <= src_t[k];
         if (reset) begin
            t_ff[k].valid <= 1'b0;
         end
      end
   end

   // round to Q1.15, renormalize and saturate
   assign m_sum = {1'b0, m_ff[15]} + 33'd16384;
   assign mr    = m_sum[32:15];
   assign ovf   = mr > 18'd65535;

   always_comb begin
      e_adj  = int'(e_ff[15]) + (ovf ? 1 : 0);
      man_in = ovf ? 16'd32768 : mr[15:0];
      exp_in = 9'(e_adj);
      if (e_adj > 255) begin
         exp_in = 9'sd255;
         man_in = 16'd65535;
      end else if (e_adj < -256) begin
         exp_in = '0;
         man_in = '0;
      end
      if (!t_ff[15].lin) begin
         exp_in = '0;
         man_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= t_ff[15];
      exp_ff <= exp_in;
      man_ff <= man_in;
      if (reset) begin
         out_ff.valid <= 1'b0;
      end
   end

   assign out_tag  = out_ff;
   assign exponent = exp_ff;
   assign mantissa = man_ff;

endmodule

// ----- rtl/core/binned_log_table_interpolator_unit.sv -----
// channel   direction  transfer condition        contents
// req_      in         start && !busy            request type, table, index, values
// rsp_      out        rsp_valid (one cycle)     status, log rate, exponent, mantissa
// csr_      in         csr_valid && csr_ready    inv_step
//
// one item is taken every cycle while busy is low; results leave in order of transfer
// most of the pipeline lies in the sixteen factor multipliers of the 10^x conversion
// entry writes and query reads meet the entry memory at the same stage, so order holds
// reset clears headers and the pipeline and sets inv_step to INV_STEP_RESET; busy and !csr_ready follow reset
// the receiver cannot stall, so there is no back pressure anywhere in the pipeline
module binned_log_table_interpolator_unit
   import blti_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [2:0]        req_table_sel,
   input  logic [8:0]        req_entry_index,
   input  logic signed [19:0] req_table_value,
   input  logic signed [19:0] req_log_temp,
   input  logic signed [19:0] req_log_abund,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic signed [19:0] rsp_log_rate,
   output logic signed [8:0] rsp_rate_exponent,
   output logic [15:0]       rsp_rate_mantissa,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   localparam int LATENCY = LOC_STAGES + INT_STAGES + EXP_STAGES;

   logic        in_valid;
   logic [15:0] inv_step_ff;
   loc_type     loc;
   tag_type     res;
   tag_type     out_tag;

   assign busy      = reset;
   assign csr_ready = !reset;
   assign in_valid  = start && !busy;

   // spacing register
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_step_ff <= INV_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         inv_step_ff <= csr_data;
      end
   end

   blti_locate #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_locate (
      .clock(clock),
      .reset(reset),
      .in_valid(in_valid),
      .req_type(req_type),
      .table_sel(req_table_sel),
      .entry_index(req_entry_index),
      .table_value(req_table_value),
      .log_temp(req_log_temp),
      .log_abund(req_log_abund),
      .inv_step(inv_step_ff),
      .loc(loc)
   );

   blti_interp #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .FRAC_BITS(FRAC_BITS)
   ) u_interp (
      .clock(clock),
      .reset(reset),
      .loc(loc),
      .res(res)
   );

   blti_exp2 #(
      .FRAC_BITS(FRAC_BITS)
   ) u_exp2 (
      .clock(clock),
      .reset(reset),
      .tag(res),
      .out_tag(out_tag),
      .exponent(rsp_rate_exponent),
      .mantissa(rsp_rate_mantissa)
   );

   // result ports
   assign rsp_valid    = out_tag.valid;
   assign rsp_status   = out_tag.status;
   assign rsp_log_rate = out_tag.lr;

   // every transfer gives exactly one result at fixed latency
   assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##LATENCY rsp_valid)
      else $error("result missing after request transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_valid, LATENCY))
      else $error("result without a request transfer");

   // write and error results carry no rate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_WRITE || rsp_status == ST_ERROR) |->
         rsp_log_rate == '0 && rsp_rate_exponent == '0 && rsp_rate_mantissa == '0)
      else $error("non-query result with nonzero rate");

   // a nonzero mantissa is normalized
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rate_mantissa != '0 |-> rsp_rate_mantissa[15])
      else $error("mantissa not normalized");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_BELOW |-> rsp_rate_mantissa == '0)
      else $error("below range result with nonzero rate");

endmodule

// ----- test/tb_binned_log_table_interpolator_unit.sv -----
module tb_binned_log_table_interpolator_unit;
   import blti_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 256;
   localparam int FB = 12;
   localparam int LATENCY = 24;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_type = '0;
   logic [2:0] req_table_sel = '0;
   logic [8:0] req_entry_index = '0;
   logic signed [19:0] req_table_value = '0;
   logic signed [19:0] req_log_temp = '0;
   logic signed [19:0] req_log_abund = '0;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic signed [19:0] rsp_log_rate;
   logic signed [8:0] rsp_rate_exponent;
   logic [15:0] rsp_rate_mantissa;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_data = '0;

   binned_log_table_interpolator_unit dut (.*);

   always #2 clock = ~clock;

   // one request and one answer
   typedef struct {
      logic [1:0] kind;
      logic [2:0] tsel;
      logic [8:0] idx;
      logic signed [19:0] tval;
      logic signed [19:0] ltemp;
      logic signed [19:0] labund;
   } request_type;

   typedef struct {
      logic [2:0] status;
      logic signed [19:0] lr;
      logic signed [8:0] ex;
      logic [15:0] ma;
   } answer_type;

   // predictor state
   logic [15:0] step_recip;
   logic signed [19:0] entry_mem [NUM_TABLES*DEPTH];
   bit entry_seen [NUM_TABLES*DEPTH];
   logic signed [19:0] hdr_start [NUM_TABLES];
   int hdr_count [NUM_TABLES];

   answer_type pending_answers [$];
   int errors = 0;
   int answers_checked = 0;
   int items_sent = 0;
   int send_idle_pct = 0;

   // log10 value to mantissa and binary exponent
   function automatic void lin_value(input longint lr, output logic signed [8:0] ex,
                                     output logic [15:0] ma);
      longint y, e;
      longint unsigned m, f;
      y = lr * 64'sd891723283;
      e = y >>> (FB + 28);
      f = (longint'(y) >> (FB + 28 - 16)) & 64'hFFFF;
      m = 64'd1 << 30;
      for (int k = 0; k < 16; k++)
         if (f[15-k]) m = (m * POW2_TAB[k] + (64'd1 << 29)) >> 30;
      m = (m + (64'd1 << 14)) >> 15;
      if (m > 65535) begin
         m = 32768;
         e++;
      end
      if (e > 255) begin
         e = 255;
         m = 65535;
      end else if (e < -256) begin
         e = 0;
         m = 0;
      end
      ex = e[8:0];
      ma = m[15:0];
   endfunction

   function automatic int pick_table(logic signed [19:0] labund);
      int tb;
      tb = 0;
      for (int i = 0; i < 7; i++)
         if (longint'(labund) > longint'(BIN_QUARTERS[i]) * (1 << (FB - 2))) tb++;
      return tb;
   endfunction

   // apply one request to the shadow tables and work out its answer
   function automatic answer_type rate_lookup(request_type r);
      answer_type a;
      int tb, cnt;
      longint st, p, j, fr, e0, e1, acc;
      a = '{ST_ERROR, '0, '0, '0};
      if (r.kind == REQ_ENTRY) begin
         if (r.idx < DEPTH) begin
            entry_mem[r.tsel*DEPTH + r.idx] = r.tval;
            entry_seen[r.tsel*DEPTH + r.idx] = 1;
            a.status = ST_WRITE;
         end
      end else if (r.kind == REQ_HEADER) begin
         if (r.idx <= DEPTH) begin
            hdr_start[r.tsel] = r.tval;
            hdr_count[r.tsel] = r.idx;
            a.status = ST_WRITE;
         end
      end else if (r.kind == REQ_QUERY) begin
         tb = pick_table(r.labund);
         cnt = hdr_count[tb];
         if (cnt != 0) begin
            st = hdr_start[tb];
            if (longint'(r.ltemp) < st) begin
               a.status = ST_BELOW;
               a.lr = LOG_RATE_FLOOR;
            end else begin
               p = (longint'(r.ltemp) - st) * longint'(step_recip);
               j = p >> (FB + 8);
               fr = p & ((64'sd1 << (FB + 8)) - 1);
               if (j > cnt - 1 || (j == cnt - 1 && fr != 0)) begin
                  a.status = ST_ABOVE;
                  a.lr = entry_mem[tb*DEPTH + cnt - 1];
               end else if (j == cnt - 1) begin
                  a.status = ST_INTERP;
                  a.lr = entry_mem[tb*DEPTH + cnt - 1];
               end else begin
                  e0 = entry_mem[tb*DEPTH + j];
                  e1 = entry_mem[tb*DEPTH + j + 1];
                  acc = (e1 - e0) * fr + (64'sd1 << (FB + 7));
                  a.status = ST_INTERP;
                  a.lr = 20'(e0 + (acc >>> (FB + 8)));
               end
               lin_value(a.lr, a.ex, a.ma);
            end
         end
      end
      return a;
   endfunction

   // a query is legal only if every entry it can read has been written
   function automatic bit query_safe(logic signed [19:0] labund);
      int tb;
      tb = pick_table(labund);
      for (int i = 0; i < hdr_count[tb]; i++)
         if (!entry_seen[tb*DEPTH + i]) return 0;
      return 1;
   endfunction

   // answer check
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected answer status %0d", $time, rsp_status);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            answers_checked++;
            if (rsp_status !== want.status || rsp_log_rate !== want.lr ||
                rsp_rate_exponent !== want.ex || rsp_rate_mantissa !== want.ma) begin
               $display("%0t: expected st %0d lr %0d ex %0d ma %0d, got st %0d lr %0d ex %0d ma %0d",
                        $time, want.status, want.lr, want.ex, want.ma, rsp_status,
                        rsp_log_rate, rsp_rate_exponent, rsp_rate_mantissa);
               errors++;
            end
         end
      end
   end

   // one request transfer, with random sender gaps
   task automatic send_request(request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= r.kind;
      req_table_sel <= r.tsel;
      req_entry_index <= r.idx;
      req_table_value <= r.tval;
      req_log_temp <= r.ltemp;
      req_log_abund <= r.labund;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_answers.push_back(rate_lookup(r));
      items_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // register write while idle
   task automatic write_step(logic [15:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      step_recip = v;
   endtask

   function automatic request_type mk(logic [1:0] k, int t, int i, int v, int lt, int la);
      request_type r;
      r = '{k, t[2:0], i[8:0], v[19:0], lt[19:0], la[19:0]};
      return r;
   endfunction

   // abundance that lands in table tb
   function automatic logic signed [19:0] abund_for(int tb);
      int lo[8] = '{-524288, -14335, -10239, -7167, -5119, -3071, -1023, 1025};
      int hi[8] = '{-14336, -10240, -7168, -5120, -3072, -1024, 1024, 524287};
      return 20'($urandom_range(hi[tb] - lo[tb]) + lo[tb]);
   endfunction

   // fill one table with a random header and every entry it uses
   task automatic load_table(int tb, int cnt);
      int st;
      st = $urandom_range(16000) - 8000;
      for (int i = 0; i < cnt; i++)
         send_request(mk(REQ_ENTRY, tb, i, $urandom_range(40000) - 20000, 0, 0));
      send_request(mk(REQ_HEADER, tb, cnt, st, 0, 0));
   endtask

   task automatic random_phase(int n);
      request_type r;
      int tb, sel;
      for (int k = 0; k < n; k++) begin
         sel = $urandom_range(99);
         tb = $urandom_range(7);
         r = mk(REQ_QUERY, 0, 0, 0, 0, 0);
         r.tsel = 3'($urandom());
         r.idx = 9'($urandom());
         r.tval = 20'($urandom());
         if (sel < 70) begin
            // query near the table span
            r.labund = abund_for(tb);
            r.ltemp = 20'(longint'(hdr_start[tb]) + $urandom_range(12000) - 1000);
            if ($urandom_range(9) == 0) r.ltemp = 20'($urandom());
         end else if (sel < 85) begin
            r.kind = REQ_ENTRY;
            r.idx = 9'($urandom_range(hdr_count[r.tsel] > 0 ? 300 : 255));
            r.tval = $urandom_range(1) ? 20'($urandom()) : 20'($urandom_range(40000) - 20000);
         end else if (sel < 93) begin
            // rewrite header, keep count within written entries
            r.kind = REQ_HEADER;
            r.idx = 9'($urandom_range(12) + 1);
            for (int i = 0; i < r.idx; i++)
               if (!entry_seen[r.tsel*DEPTH + i]) r.idx = '0;
            if ($urandom_range(4) == 0) r.idx = 9'(257 + $urandom_range(254));
            r.tval = 20'($urandom_range(16000) - 8000);
         end else begin
            r.kind = 2'd3;
         end
         r.ltemp = r.kind == REQ_QUERY ? r.ltemp : 20'($urandom());
         r.labund = r.kind == REQ_QUERY ? r.labund : 20'($urandom());
         if (r.kind == REQ_QUERY && !query_safe(r.labund)) r.kind = 2'd3;
         send_request(r);
      end
   endtask

   // directed table: expected answers for the obvious rows
   request_type dir_req [$];
   answer_type dir_want [$];
   bit dir_known [$];

   task automatic add_row(request_type r, bit known, answer_type w);
      dir_req.push_back(r);
      dir_known.push_back(known);
      dir_want.push_back(w);
   endtask

   initial begin
      answer_type none, w, err, wr;
      none = '{ST_ERROR, '0, '0, '0};
      err = none;
      wr = '{ST_WRITE, '0, '0, '0};
      step_recip = INV_STEP_RESET;
      for (int i = 0; i < NUM_TABLES*DEPTH; i++) begin
         entry_mem[i] = '0;
         entry_seen[i] = 0;
      end
      for (int i = 0; i < NUM_TABLES; i++) begin
         hdr_start[i] = '0;
         hdr_count[i] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles first
      send_idle_pct = 20;

      // directed part
      add_row(mk(REQ_QUERY, 0, 0, 0, 0, 0), 1, err);
      add_row(mk(2'd3, 7, 511, -1, -1, -1), 1, err);
      add_row(mk(REQ_ENTRY, 3, 256, 5, 0, 0), 1, err);
      add_row(mk(REQ_HEADER, 3, 257, 5, 0, 0), 1, err);
      add_row(mk(REQ_ENTRY, 7, 255, 524287, 0, 0), 1, wr);
      add_row(mk(REQ_ENTRY, 0, 0, -524288, 0, 0), 1, wr);
      add_row(mk(REQ_ENTRY, 0, 1, 524287, 0, 0), 1, wr);
      add_row(mk(REQ_ENTRY, 0, 2, 4096, 0, 0), 1, wr);
      add_row(mk(REQ_HEADER, 0, 3, 0, 0, 0), 1, wr);
      w = '{ST_BELOW, LOG_RATE_FLOOR, '0, '0};
      add_row(mk(REQ_QUERY, 0, 0, 0, -1, -524288), 1, w);
      add_row(mk(REQ_QUERY, 0, 0, 0, 0, -524288), 0, none);
      add_row(mk(REQ_QUERY, 0, 0, 0, 100, -14336), 0, none);
      add_row(mk(REQ_QUERY, 0, 0, 0, 205, -14336), 0, none);
      add_row(mk(REQ_QUERY, 0, 0, 0, 410, -14336), 0, none);
      add_row(mk(REQ_QUERY, 0, 0, 0, 409, -14336), 0, none);
      add_row(mk(REQ_QUERY, 0, 0, 0, 524287, -14336), 0, none);
      add_row(mk(REQ_QUERY, 0, 0, 0, 0, -14335), 1, err);
      add_row(mk(REQ_QUERY, 0, 0, 0, 0, 524287), 1, err);
      for (int i = 0; i < dir_req.size(); i++) begin
         send_request(dir_req[i]);
         if (dir_known[i]) pending_answers[$] = dir_want[i];
      end
      // load all tables, then walk the register through extremes
      for (int tb = 0; tb < NUM_TABLES; tb++) load_table(tb, tb == 5 ? 256 : 2 + tb);
      write_step(16'd65535);
      random_phase(150);
      write_step(16'd1);
      random_phase(150);
      write_step(16'd0);
      random_phase(50);
      write_step(16'd5120);
      random_phase(700);

      // sender idles most of the time, then no idling
      write_step(16'd20000);
      send_idle_pct = 78;
      random_phase(300);
      send_idle_pct = 0;
      random_phase(300);
      drain();

      $display("sent %0d items, checked %0d answers across five step settings",
               items_sent, answers_checked);
      $display("sender gaps of 20, 78 and 0 percent, with back to back transfers");
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // timeout
   initial begin
      #4ms;
      $display("simulation failed");
      $finish;
   end
endmodule

// ----- files.f -----
rtl/core/blti_pkg.sv
rtl/core/blti_locate.sv
rtl/core/blti_interp.sv
rtl/core/blti_exp2.sv
rtl/core/binned_log_table_interpolator_unit.sv
test/tb_binned_log_table_interpolator_unit.sv
